[sv/scs1_pkg.sv]
// Shared types and constants for the set-1 scan code decoder.
// Holds the action codes, key codes, stage struct and the key table.
// No dependencies.
`default_nettype none

package scs1_pkg;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_CHAR      = 3'd1,
    ACT_BACKSPACE = 3'd2,
    ACT_CAPTURE   = 3'd3,
    ACT_FONT_DOWN = 3'd4,
    ACT_FONT_UP   = 3'd5
  } action_t;

  localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT  = 8'h36;
  localparam logic [7:0] KEY_CAPS    = 8'h3A;
  localparam logic [7:0] KEY_CTRL    = 8'h1D;
  localparam logic [7:0] KEY_SPACE   = 8'h39;
  localparam logic [7:0] BREAK_BIT   = 8'h80;
  localparam logic [7:0] MAKE_LOW    = 8'h01;
  localparam logic [7:0] MAKE_HIGH   = 8'h3A;
  localparam logic [7:0] BREAK_LOW   = 8'h81;
  localparam logic [7:0] BREAK_HIGH  = 8'hBA;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_PERIOD    = 8'h2E;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

  localparam int unsigned KEY_DEPTH = 64;
  localparam int unsigned KEY_AW    = $clog2(KEY_DEPTH);

  // Character for each make code, indexed by the low six bits of the code.
  localparam logic [7:0] KEY_TABLE [KEY_DEPTH] = '{
    8'hFA, 8'hFA, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Lookup stage contents handed to the decode stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic [7:0] key;
  } lookup_t;

endpackage

`default_nettype wire

[sv/scs1_if.sv]
// Valid/ready channel interfaces for the scan code decoder.
// Depends on scs1_pkg for the action type.
`default_nettype none

interface scs1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface

interface scs1_out_if;
  import scs1_pkg::*;
  logic       valid;
  logic       ready;
  action_t    action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

`default_nettype wire

[sv/scs1_key_rom.sv]
// Lookup stage: synchronous, registered key table read.
// Depends on scs1_pkg for the table and the stage struct.
`default_nettype none

module scs1_key_rom (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [7:0]        code,
  input  wire logic              take,
  output scs1_pkg::lookup_t      stage
);
  import scs1_pkg::*;

  logic [7:0] rom_mem [KEY_DEPTH];
  logic       valid_r, valid_nxt;
  logic [7:0] code_r;
  logic [7:0] key_r;

  always_comb begin
    for (int i = 0; i < KEY_DEPTH; i++) begin
      rom_mem[i] = KEY_TABLE[i];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= code;
      key_r  <= rom_mem[code[KEY_AW-1:0]];
    end
  end

  assign stage.valid = valid_r;
  assign stage.code  = code_r;
  assign stage.key   = key_r;

endmodule

`default_nettype wire

[sv/scs1_decode.sv]
// Decode stage: modifier flags, action selection and the result register.
// Depends on scs1_pkg for action codes, key codes and the stage struct.
`default_nettype none

module scs1_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scs1_pkg::lookup_t stage,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output scs1_pkg::action_t      out_action,
  output logic [7:0]             out_char
);
  import scs1_pkg::*;

  logic       shift_r, shift_nxt;
  logic       ctrl_r, ctrl_nxt;
  logic       caps_r, caps_nxt;
  logic       valid_r, valid_nxt;
  action_t    action_r, action_nxt;
  logic [7:0] char_r, char_nxt;

  assign take = stage.valid && (!valid_r || out_ready);

  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    caps_nxt   = caps_r;
    action_nxt = ACT_NONE;
    char_nxt   = 8'h00;
    if (stage.code inside {[MAKE_LOW:MAKE_HIGH]}) begin
      if (stage.code == KEY_CTRL) begin
        ctrl_nxt = 1'b1;
      end else if (stage.code == KEY_LSHIFT || stage.code == KEY_RSHIFT) begin
        shift_nxt = 1'b1;
      end else if (stage.code == KEY_CAPS) begin
        caps_nxt = !caps_r;
      end else if (stage.code == KEY_SPACE) begin
        action_nxt = ACT_CHAR;
        char_nxt   = CH_SPACE;
      end else if (ctrl_r && stage.key == CH_LOWER_R) begin
        action_nxt = ACT_CAPTURE;
      end else if (ctrl_r && stage.key == CH_COMMA) begin
        action_nxt = ACT_FONT_DOWN;
      end else if (ctrl_r && stage.key == CH_PERIOD) begin
        action_nxt = ACT_FONT_UP;
      end else if (stage.key == CH_BACKSPACE) begin
        action_nxt = ACT_BACKSPACE;
      end else if (stage.key != 8'h00) begin
        action_nxt = ACT_CHAR;
        char_nxt   = stage.key;
        // Only letters are case-converted; punctuation and escape pass unchanged.
        if ((shift_r || caps_r) && stage.key inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
          char_nxt = stage.key - CASE_OFFSET;
        end
      end
    end else if (stage.code inside {[BREAK_LOW:BREAK_HIGH]}) begin
      if (stage.code == (KEY_LSHIFT | BREAK_BIT) ||
          stage.code == (KEY_RSHIFT | BREAK_BIT)) begin
        shift_nxt = 1'b0;
      end else if (stage.code == (KEY_CTRL | BREAK_BIT)) begin
        ctrl_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      caps_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        caps_r  <= caps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action_r <= action_nxt;
      char_r   <= char_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_action = action_r;
  assign out_char   = char_r;

endmodule

`default_nettype wire

[sv/scancode_set1_keyboard_decoder_unit.sv]
// Top level of the set-1 scan code decoder: key table lookup, then decode.
// Depends on scs1_pkg, scs1_if, scs1_key_rom and scs1_decode.
//
//   Channel   Dir   Payload               Handshake
//   in_req    in    scan_code[7:0]        valid / ready
//   out_res   out   action[2:0], char[7:0] valid / ready
//
// One request is accepted per cycle unless a stalled result backs up into the lookup stage;
// each gives exactly one result, via the registered key table read and the result register.
// The modifier flags are updated in the decode stage, so back-to-back codes see
// the flags left by the code just before them. Reset clears flags and valids.
// A stalled result holds the result register; the lookup stage still fills behind it.
`default_nettype none

module scancode_set1_keyboard_decoder_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scs1_in_if.sink     in_req,
  scs1_out_if.source  out_res
);
  import scs1_pkg::*;

  lookup_t stage;
  logic    take;
  logic    in_fire;

  assign in_req.ready = !stage.valid || take;
  assign in_fire      = in_req.valid && in_req.ready;

  scs1_key_rom u_key_rom (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .code  (in_req.scan_code),
    .take  (take),
    .stage (stage)
  );

  scs1_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .take       (take),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_action (out_res.action),
    .out_char   (out_res.char_code)
  );

  a_fill_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> stage.valid)
    else $error("accepted request did not reach the lookup stage");

  a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && !out_res.valid) |-> take)
    else $error("lookup stage stalled behind an empty result register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (stage.valid && out_res.valid && !out_res.ready))
    else $error("input stalled while the pipeline could advance");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.action != ACT_CHAR) |-> (out_res.char_code == 8'h00))
    else $error("non-character result carries a character code");

endmodule

`default_nettype wire
